// ===== hdl/rld_pkg.sv =====
// ----------------------------------------------------------------------------
// rld_pkg
// Shared widths, register indexes, reset values and helpers for the ray luma
// edge detector.
// ----------------------------------------------------------------------------
`default_nettype none

package rld_pkg;

    localparam int LUMA_W  = 8;
    localparam int DERIV_W = 10;
    localparam int MAG_W   = 9;
    localparam int IDX_W   = 10;
    localparam int THR_W   = 8;
    localparam int STEP_W  = 15;
    localparam int DIST_W  = 15;
    localparam int PROD_W  = IDX_W + STEP_W;
    localparam int DIST_SHIFT = 10;
    localparam int WIN_DEPTH  = 4;

    localparam int MAX_RAY_SAMPLES = 1024;
    localparam logic [IDX_W-1:0] COUNT_MAX =
        (MAX_RAY_SAMPLES > (1 << IDX_W)) ? IDX_W'((1 << IDX_W) - 1)
                                         : IDX_W'(MAX_RAY_SAMPLES - 1);

    localparam logic [IDX_W-1:0] MIN_EDGE_COUNT  = IDX_W'(5);
    localparam logic [IDX_W-1:0] CENTER_OFFSET   = IDX_W'(3);
    localparam logic [LUMA_W-1:0] LUMA_RESET     = LUMA_W'(127);

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RAY_STEP_Q14   = 1'b1;
    localparam logic [THR_W-1:0]  THRESHOLD_RESET = THR_W'(20);
    localparam logic [STEP_W-1:0] RAY_STEP_RESET  = STEP_W'(16384);

    typedef struct packed {
        logic             rising_edge;
        logic [IDX_W-1:0] edge_index;
    } edge_cand_t;

    function automatic logic [MAG_W-1:0] abs_mag(input logic signed [DERIV_W-1:0] v);
        logic signed [DERIV_W-1:0] neg;
        neg = -v;
        return v[DERIV_W-1] ? neg[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rld_in_if.sv =====
// ----------------------------------------------------------------------------
// rld_in_if
// Sample channel: one luma sample with its mask and ray-start flags per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rld_in_if
    import rld_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [LUMA_W-1:0] luma;
    logic              masked_sample;
    logic              ray_start;

    modport source (output valid, output luma, output masked_sample,
                    output ray_start, input ready);
    modport sink   (input valid, input luma, input masked_sample,
                    input ray_start, output ready);
endinterface

`default_nettype wire

// ===== hdl/rld_out_if.sv =====
// ----------------------------------------------------------------------------
// rld_out_if
// Edge report channel: polarity, centered index and distance per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rld_out_if
    import rld_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              rising_edge;
    logic [IDX_W-1:0]  edge_index;
    logic [DIST_W-1:0] edge_distance_q4;

    modport source (output valid, output rising_edge, output edge_index,
                    output edge_distance_q4, input ready);
    modport sink   (input valid, input rising_edge, input edge_index,
                    input edge_distance_q4, output ready);
endinterface

`default_nettype wire

// ===== hdl/rld_deriv.sv =====
// ----------------------------------------------------------------------------
// rld_deriv
// Sample window, doubled derivative and peak test. State advances on every
// accepted sample; the edge decision for that sample is combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module rld_deriv
    import rld_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [LUMA_W-1:0] luma,
    input  wire logic              masked_sample,
    input  wire logic              ray_start,
    input  wire logic [THR_W-1:0]  edge_threshold,
    output logic                   hit,
    output edge_cand_t             cand
);

    logic [LUMA_W-1:0]         luma_win_reg [WIN_DEPTH];
    logic [WIN_DEPTH-1:0]      mask_win_reg;
    logic signed [DERIV_W-1:0] prev_deriv_reg;
    logic signed [DERIV_W-1:0] older_deriv_reg;
    logic                      prev_valid_reg;
    logic [IDX_W-1:0]          count_reg;

    logic [LUMA_W-1:0]         w0, w1, w2;
    logic                      any_mask;
    logic signed [DERIV_W-1:0] prev_d, older_d, deriv;
    logic                      prev_ok;
    logic [IDX_W-1:0]          count;
    logic [MAG_W-1:0]          t2, mag_d, mag_p, mag_o;
    logic                      valid_now;
    logic [IDX_W-1:0]          count_next;

    // a ray start sees the cleared window
    always_comb
    begin
        w0       = ray_start ? LUMA_RESET : luma_win_reg[0];
        w1       = ray_start ? LUMA_RESET : luma_win_reg[1];
        w2       = ray_start ? LUMA_RESET : luma_win_reg[2];
        any_mask = masked_sample | ray_start | (|mask_win_reg);
        prev_d   = ray_start ? '0 : prev_deriv_reg;
        older_d  = ray_start ? '0 : older_deriv_reg;
        prev_ok  = ray_start ? 1'b0 : prev_valid_reg;
        count    = ray_start ? '0 : count_reg;
    end

    // window entry 3 is cleared to the same value as entry 2 on ray start
    logic [LUMA_W-1:0] w3;
    assign w3 = ray_start ? LUMA_RESET : luma_win_reg[3];

    assign deriv = $signed({2'b00, luma}) + $signed({2'b00, w0})
                 - $signed({2'b00, w2}) - $signed({2'b00, w3});

    assign t2    = {edge_threshold, 1'b0};
    assign mag_d = abs_mag(deriv);
    assign mag_p = abs_mag(prev_d);
    assign mag_o = abs_mag(older_d);

    assign valid_now = (count > MIN_EDGE_COUNT) && (mag_d > t2) && !any_mask;

    assign hit = (count >= MIN_EDGE_COUNT) && (mag_p > t2) && (mag_p > mag_o)
              && (mag_p > mag_d) && prev_ok;

    assign cand.rising_edge = !prev_d[DERIV_W-1] && (prev_d != '0);
    assign cand.edge_index  = count - CENTER_OFFSET;

    assign count_next = (count < COUNT_MAX) ? count + IDX_W'(1) : count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                luma_win_reg[i] <= LUMA_RESET;
            end
            mask_win_reg    <= '1;
            prev_deriv_reg  <= '0;
            older_deriv_reg <= '0;
            prev_valid_reg  <= 1'b0;
            count_reg       <= '0;
        end
        else if (accept)
        begin
            luma_win_reg[0] <= luma;
            luma_win_reg[1] <= w0;
            luma_win_reg[2] <= w1;
            luma_win_reg[3] <= w2;
            mask_win_reg    <= ray_start ? {{(WIN_DEPTH-1){1'b1}}, masked_sample}
                                         : {mask_win_reg[WIN_DEPTH-2:0], masked_sample};
            older_deriv_reg <= prev_d;
            prev_deriv_reg  <= deriv;
            prev_valid_reg  <= valid_now;
            count_reg       <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rld_scale.sv =====
// ----------------------------------------------------------------------------
// rld_scale
// Edge candidate register, index-to-distance multiply and output register,
// with the ready chain for the two pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

module rld_scale
    import rld_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic              hit,
    input  wire edge_cand_t        cand,
    input  wire logic [STEP_W-1:0] ray_step_q14,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   rising_edge,
    output logic [IDX_W-1:0]       edge_index,
    output logic [DIST_W-1:0]      edge_distance_q4
);

    logic              s1_valid_reg, s1_valid_next;
    edge_cand_t        s1_cand_reg;
    logic              out_valid_reg, out_valid_next;
    logic              rising_reg;
    logic [IDX_W-1:0]  index_reg;
    logic [DIST_W-1:0] dist_reg;
    logic              s1_adv;
    logic [PROD_W-1:0] prod;

    assign s1_adv   = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = hit;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = s1_adv ? s1_valid_reg : out_valid_reg;
    end

    assign prod = PROD_W'(s1_cand_reg.edge_index) * PROD_W'(ray_step_q14);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && hit)
        begin
            s1_cand_reg <= cand;
        end
        if (s1_adv && s1_valid_reg)
        begin
            rising_reg <= s1_cand_reg.rising_edge;
            index_reg  <= s1_cand_reg.edge_index;
            dist_reg   <= prod[DIST_SHIFT +: DIST_W];
        end
    end

    assign out_valid        = out_valid_reg;
    assign rising_edge      = rising_reg;
    assign edge_index       = index_reg;
    assign edge_distance_q4 = dist_reg;

endmodule

`default_nettype wire

// ===== hdl/ray_luma_edge_detector_core.sv =====
// ----------------------------------------------------------------------------
// ray_luma_edge_detector_core
// Edge peak detector along one ray of luma samples, with a plain register
// write port for the threshold and the ray step.
// ----------------------------------------------------------------------------
// Path: an edge report passes the candidate register, then the multiply into
//   the output register, after the sample revealing the peak is accepted.
// Throughput: one sample per cycle; input waits only while the output is
//   stalled and a second report sits in the candidate register.
// Reset: rst_n clears the window to mid gray and masked, the derivatives,
//   the sample counter and both stages; registers return to 20 and 1.0.
`default_nettype none

module ray_luma_edge_detector_core
    import rld_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    rld_in_if.sink                     in_ch,
    rld_out_if.source                  out_ch,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [THR_W-1:0]  threshold_reg;
    logic [STEP_W-1:0] ray_step_reg;
    logic              accept;
    logic              edge_hit;
    edge_cand_t        edge_cand;
    logic              in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            ray_step_reg  <= RAY_STEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_EDGE_THRESHOLD: threshold_reg <= cfg_data[THR_W-1:0];
                REG_RAY_STEP_Q14:   ray_step_reg  <= cfg_data[STEP_W-1:0];
                default:            ;
            endcase
        end
    end

    assign in_ch.ready = in_ready;
    assign accept      = in_ch.valid && in_ready;

    rld_deriv u_deriv (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .luma           (in_ch.luma),
        .masked_sample  (in_ch.masked_sample),
        .ray_start      (in_ch.ray_start),
        .edge_threshold (threshold_reg),
        .hit            (edge_hit),
        .cand           (edge_cand)
    );

    rld_scale u_scale (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .hit              (edge_hit),
        .cand             (edge_cand),
        .ray_step_q14     (ray_step_reg),
        .in_ready         (in_ready),
        .out_valid        (out_ch.valid),
        .out_ready        (out_ch.ready),
        .rising_edge      (out_ch.rising_edge),
        .edge_index       (out_ch.edge_index),
        .edge_distance_q4 (out_ch.edge_distance_q4)
    );

    // input only backs up behind a full output register
    a_ready_needs_full_out: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_ch.valid)
        else $error("input stalled with empty output register");

    // a ray start restarts the count, so it can never reveal an edge
    a_no_edge_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ray_start) |-> !edge_hit)
        else $error("edge flagged on ray start sample");

    // reports need at least five samples, so the centered index is at least two
    a_min_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.edge_index >= IDX_W'(2)))
        else $error("edge index below window center");

endmodule

`default_nettype wire

// ===== sim/edge_report_checker.sv =====
// ----------------------------------------------------------------------------
// edge_report_checker
// Watches the sample, edge report and register write ports of the ray luma
// edge detector, predicts each edge report from the accepted samples and
// compares every accepted report word against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module edge_report_checker
    import rld_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    rld_in_if                          in_ch,
    rld_out_if                         out_ch,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         mismatch_count,
    output int                         reports_pending
);

    typedef struct packed {
        logic              rising_edge;
        logic [IDX_W-1:0]  edge_index;
        logic [DIST_W-1:0] edge_distance_q4;
    } edge_report_t;

    edge_report_t reports_due[$];

    logic [THR_W-1:0]          threshold;
    logic [STEP_W-1:0]         ray_step;
    logic [LUMA_W-1:0]         luma_hist [WIN_DEPTH];
    logic                      mask_hist [WIN_DEPTH];
    logic signed [DERIV_W-1:0] last_deriv;
    logic signed [DERIV_W-1:0] older_deriv;
    logic                      last_deriv_ok;
    logic [IDX_W-1:0]          sample_idx;

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic clear_window();
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            luma_hist[i] = LUMA_RESET;
            mask_hist[i] = 1'b1;
        end
        last_deriv    = '0;
        older_deriv   = '0;
        last_deriv_ok = 1'b0;
        sample_idx    = '0;
    endtask

    task automatic predict_edge(input logic [LUMA_W-1:0] y, input logic m,
                                input logic start);
        int                deriv;
        int                thr2;
        int                peak;
        logic              any_mask;
        logic [IDX_W-1:0]  idx;
        logic [PROD_W-1:0] prod;
        edge_report_t      rpt;
        if (start)
            clear_window();
        deriv = int'(y) + int'(luma_hist[0]) - int'(luma_hist[2]) - int'(luma_hist[3]);
        thr2  = 2 * int'(threshold);
        peak  = magnitude(int'(last_deriv));
        any_mask = m | mask_hist[0] | mask_hist[1] | mask_hist[2] | mask_hist[3];

        // the previous derivative is the candidate; the new one is its right side
        if (sample_idx >= MIN_EDGE_COUNT && peak > thr2 && last_deriv_ok &&
            peak > magnitude(int'(older_deriv)) && peak > magnitude(deriv))
        begin
            idx  = sample_idx - CENTER_OFFSET;
            prod = PROD_W'(idx) * PROD_W'(ray_step);
            rpt.rising_edge      = (last_deriv > 0);
            rpt.edge_index       = idx;
            rpt.edge_distance_q4 = prod[DIST_SHIFT +: DIST_W];
            reports_due = {reports_due, rpt};
        end

        // validity keeps the threshold in force at the time it is formed
        older_deriv   = last_deriv;
        last_deriv    = DERIV_W'(deriv);
        last_deriv_ok = (sample_idx > MIN_EDGE_COUNT) && (magnitude(deriv) > thr2)
                        && !any_mask;
        for (int i = WIN_DEPTH - 1; i > 0; i--)
        begin
            luma_hist[i] = luma_hist[i-1];
            mask_hist[i] = mask_hist[i-1];
        end
        luma_hist[0] = y;
        mask_hist[0] = m;
        if (sample_idx < COUNT_MAX)
            sample_idx = sample_idx + 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        edge_report_t want;
        if (!rst_n)
        begin
            threshold = THRESHOLD_RESET;
            ray_step  = RAY_STEP_RESET;
            clear_window();
            reports_due.delete();
            mismatch_count  = 0;
            reports_pending = 0;
        end
        else
        begin
            // compare before predicting: a word out now stems from older samples
            if (out_ch.valid && out_ch.ready)
            begin
                if (reports_due.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: expected no edge word, got rising=%0d index=%0d dist=%0d",
                             $time, out_ch.rising_edge, out_ch.edge_index,
                             out_ch.edge_distance_q4);
                end
                else
                begin
                    want = reports_due.pop_front();
                    if (out_ch.rising_edge !== want.rising_edge ||
                        out_ch.edge_index !== want.edge_index ||
                        out_ch.edge_distance_q4 !== want.edge_distance_q4)
                    begin
                        mismatch_count++;
                        $display("%0t: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 $time, want.rising_edge, want.edge_index,
                                 want.edge_distance_q4, out_ch.rising_edge,
                                 out_ch.edge_index, out_ch.edge_distance_q4);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                predict_edge(in_ch.luma, in_ch.masked_sample, in_ch.ray_start);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_EDGE_THRESHOLD: threshold = cfg_data[THR_W-1:0];
                    REG_RAY_STEP_Q14:   ray_step  = cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            reports_pending = reports_due.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives luma samples along rays into the edge detector: a short directed
// part with clean rising and falling ramps, then phases of random rays and
// noise under different thresholds, ray steps and handshake idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import rld_pkg::*;

    localparam int PHASE_ITEMS = 110;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatch_count;
    int                    reports_pending;
    int                    tx_idle_pct = 0;
    int                    rx_stall_pct = 0;

    rld_in_if  in_ch();
    rld_out_if out_ch();

    ray_luma_edge_detector_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    edge_report_checker report_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .reports_pending (reports_pending)
    );

    always #1 clk = ~clk;

    initial
    begin
        #2000000;
        $display("ray_luma_edge_detector_core test failed");
        $finish;
    end

    // receiver: stall at random per cycle
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready = rst_n && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_sample(input logic [LUMA_W-1:0] y, input logic m,
                               input logic start);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.luma          = y;
        in_ch.masked_sample = m;
        in_ch.ray_start     = start;
        in_ch.valid         = 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        in_ch.valid = 1'b0;
        while (reports_pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        hold_until_drained();
        // wait with no sample in flight before writing the register
        repeat (6) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // plateaus with small noise give clean steps; a few masked samples
    task automatic send_ray(input logic fresh, input int len);
        int level;
        int y;
        level = $urandom_range(255);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(7) == 0)
                level = $urandom_range(255);
            y = level + $urandom_range(6) - 3;
            if (y < 0)
                y = 0;
            if (y > 255)
                y = 255;
            send_sample(LUMA_W'(y), $urandom_range(24) == 0, fresh && k == 0);
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct,
                             input logic [THR_W-1:0] thr,
                             input logic [STEP_W-1:0] step,
                             input int items, input logic hold_mid);
        int   sent;
        int   len;
        logic first;
        logic held;
        // upper data bits of the threshold write are junk and must be dropped
        write_reg(REG_EDGE_THRESHOLD,
                  CFG_DATA_W'(($urandom_range(127) << THR_W) | thr));
        write_reg(REG_RAY_STEP_Q14, CFG_DATA_W'(step));
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        sent  = 0;
        first = 1'b1;
        held  = 1'b0;
        while (sent < items)
        begin
            if (hold_mid && !held && sent >= items / 2)
            begin
                hold_until_drained();
                held = 1'b1;
            end
            if ($urandom_range(9) < 8)
            begin
                // first ray continues across the register change
                len = $urandom_range(6, 40);
                send_ray(!first, len);
                sent += len;
            end
            else
            begin
                len = $urandom_range(1, 6);
                repeat (len)
                    send_sample(LUMA_W'($urandom_range(255)), 1'($urandom_range(1)),
                                $urandom_range(9) == 0);
                sent += len;
            end
            first = 1'b0;
        end
    endtask

    initial
    begin
        logic [LUMA_W-1:0] ramp[12];
        ramp = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd128,
                 8'd255, 8'd255, 8'd255, 8'd255};
        in_ch.valid         = 1'b0;
        in_ch.luma          = '0;
        in_ch.masked_sample = 1'b0;
        in_ch.ray_start     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_EDGE_THRESHOLD;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // from reset with no ray start: rising ramp, then a new ray falling
        for (int i = 0; i < 12; i++)
            send_sample(ramp[i], 1'b0, 1'b0);
        for (int i = 0; i < 12; i++)
            send_sample(ramp[11-i], 1'b0, i == 0);

        run_phase(0, 0, 8'd0, STEP_W'(23170), PHASE_ITEMS, 1'b0);
        run_phase(68, 0, 8'd255, STEP_W'(16384), PHASE_ITEMS, 1'b0);
        run_phase(0, 68, 8'd20, STEP_W'($urandom_range(16384, 23170)),
                  PHASE_ITEMS, 1'b1);
        run_phase(36, 36, THR_W'($urandom_range(1, 254)),
                  STEP_W'($urandom_range(16384, 23170)), PHASE_ITEMS, 1'b0);

        hold_until_drained();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0)
            $display("ray_luma_edge_detector_core test passed");
        else
            $display("ray_luma_edge_detector_core test failed");
        $finish;
    end

endmodule
